// File: hw/rtl/tsort_pkg.sv
// Shared types and constants of the topological sort core.
// Holds the word layouts, status codes and the controller/datapath command bundle.
// No dependencies.
package tsort_pkg;

	localparam int VID_W = 6;
	localparam int NV_W = 7;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF = 256;

	typedef logic [VID_W-1:0] vid_t;
	typedef logic [NV_W-1:0] nv_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] deg_op_t;
	typedef logic [1:0] out_kind_t;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_CYCLE = 2'd1;
	localparam status_t ST_FULL = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	localparam deg_op_t DEG_NONE = 2'd0;
	localparam deg_op_t DEG_ZERO = 2'd1;
	localparam deg_op_t DEG_INC = 2'd2;
	localparam deg_op_t DEG_DEC = 2'd3;

	localparam out_kind_t OUT_ADD = 2'd0;
	localparam out_kind_t OUT_CYCLE = 2'd1;
	localparam out_kind_t OUT_VERTEX = 2'd2;

	typedef struct packed {
		logic opcode;
		vid_t edge_source;
		vid_t edge_target;
	} in_word_t;

	typedef struct packed {
		status_t status;
		vid_t vertex_id;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic idx_clr;
		logic idx_inc;
		logic eidx_clr;
		logic eidx_inc;
		logic q_clr;
		logic pop;
		logic enq;
		logic enq_sel_idx;
		logic deg_sel_idx;
		logic q_sel_idx;
		deg_op_t deg_op;
		logic add_commit;
		logic edge_clr;
		logic out_load;
		out_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic idx_end;
		logic edge_end;
		logic edge_live;
		logic edge_match;
		logic deg_zero;
		logic deg_one;
		logic q_empty;
		logic cycle;
		logic out_free;
	} stat_t;

endpackage

// File: hw/rtl/topological_sort_cycle_detect_core.sv
// Top level of the topological sort core with cycle detection.
// Depends on tsort_pkg, tsort_ctrl and tsort_dp.
//
// Usage: words enter on in_valid/in_ready and results leave on out_valid/out_ready.
// An add-edge word is captured in the IDLE state and its one status word is
// loaded into the output register in the ADD state once that register is free.
// A run word clears the in-degrees, counts them over the stored edges, seeds the
// queue, then for each popped vertex scans all stored edges.
// It then gives one cycle word, or n vertex words; last marks the final word.
// Run time is set by the single port of the edge store that each scan walks.
// One word is worked at a time; the next is taken once the previous one has
// handed its last result to the output register, even while that result waits.
// A stalled receiver holds the output register and pauses the block.
// The user writes num_vertices through cfg_we/cfg_data only while idle; the
// block itself does not enforce this.
// Reset empties the edge store and sets num_vertices to 1; no clearing pass.
module topological_sort_cycle_detect_core #(
	parameter int MAX_VERTICES = tsort_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES = tsort_pkg::MAX_EDGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tsort_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_ready,
	output tsort_pkg::out_word_t out_word,
	input logic cfg_we,
	input tsort_pkg::nv_t cfg_data
);

	tsort_pkg::cmd_t cmd;
	tsort_pkg::stat_t stat;

	tsort_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(in_word.opcode),
		.stat(stat),
		.cmd(cmd)
	);

	tsort_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_word(in_word),
		.cmd(cmd),
		.stat(stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output word overwritten before taken");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a word is in progress");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_word.status != tsort_pkg::ST_OK)) |-> out_word.last)
		else $error("non-vertex result without last");
`endif

endmodule

// File: hw/rtl/tsort_dp.sv
// Datapath of the topological sort core: edge store, in-degree and order memories,
// counters, configuration register and output word register.
// Depends on tsort_pkg; driven by tsort_ctrl through cmd_t.
module tsort_dp #(
	parameter int MAX_VERTICES = tsort_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES = tsort_pkg::MAX_EDGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input tsort_pkg::nv_t cfg_data,
	input tsort_pkg::in_word_t in_word,
	input tsort_pkg::cmd_t cmd,
	output tsort_pkg::stat_t stat,
	output logic out_valid,
	input logic out_ready,
	output tsort_pkg::out_word_t out_word
);

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EW = 2 * tsort_pkg::VID_W;
	localparam tsort_pkg::nv_t NMAX = tsort_pkg::nv_t'(MAX_VERTICES);
	localparam logic [ECW-1:0] ECAP = ECW'(MAX_EDGES);

	logic [EW-1:0] estore [MAX_EDGES];
	logic [ECW-1:0] deg_mem [MAX_VERTICES];
	tsort_pkg::vid_t q_mem [MAX_VERTICES];

	tsort_pkg::nv_t nv_q, idx_q, head_q, tail_q, n_eff;
	logic [ECW-1:0] edge_cnt_q, eidx_q;
	tsort_pkg::vid_t src_q, dst_q, cur_v_q, q_rd_q, edge_f, edge_t, enq_data;
	logic [EW-1:0] edge_rd_q;
	logic [ECW-1:0] deg_rd_q, deg_wdata;
	logic [VAW-1:0] deg_addr, q_addr;
	logic out_valid_q;
	tsort_pkg::out_word_t out_q, out_next;
	tsort_pkg::status_t add_status;
	logic add_ok, deg_we, enq_we;

	assign n_eff = (nv_q == '0) ? tsort_pkg::nv_t'(1) : ((nv_q > NMAX) ? NMAX : nv_q);
	assign edge_f = edge_rd_q[EW-1:tsort_pkg::VID_W];
	assign edge_t = edge_rd_q[tsort_pkg::VID_W-1:0];
	assign deg_addr = cmd.deg_sel_idx ? idx_q[VAW-1:0] : edge_t[VAW-1:0];
	assign q_addr = cmd.q_sel_idx ? idx_q[VAW-1:0] : head_q[VAW-1:0];
	assign enq_data = cmd.enq_sel_idx ? tsort_pkg::vid_t'(idx_q) : edge_t;
	assign enq_we = cmd.enq && (tail_q < NMAX);
	assign deg_we = (cmd.deg_op != tsort_pkg::DEG_NONE);

	always_comb begin
		unique case (cmd.deg_op)
			tsort_pkg::DEG_INC: deg_wdata = deg_rd_q + ECW'(1);
			tsort_pkg::DEG_DEC: deg_wdata = deg_rd_q - ECW'(1);
			default: deg_wdata = '0;
		endcase
	end

	always_comb begin
		if (({1'b0, src_q} >= n_eff) || ({1'b0, dst_q} >= n_eff)) begin
			add_status = tsort_pkg::ST_RANGE;
		end else if (edge_cnt_q == ECAP) begin
			add_status = tsort_pkg::ST_FULL;
		end else begin
			add_status = tsort_pkg::ST_OK;
		end
	end
	assign add_ok = (add_status == tsort_pkg::ST_OK);

	always_comb begin
		out_next = '0;
		unique case (cmd.out_kind)
			tsort_pkg::OUT_ADD: begin
				out_next.status = add_status;
				out_next.last = 1'b1;
			end
			tsort_pkg::OUT_CYCLE: begin
				out_next.status = tsort_pkg::ST_CYCLE;
				out_next.last = 1'b1;
			end
			tsort_pkg::OUT_VERTEX: begin
				out_next.status = tsort_pkg::ST_OK;
				out_next.vertex_id = q_rd_q;
				out_next.last = stat.idx_last;
			end
			default: out_next = '0;
		endcase
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (cmd.add_commit && add_ok) begin
			estore[edge_cnt_q[EAW-1:0]] <= {src_q, dst_q};
		end
		edge_rd_q <= estore[eidx_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_addr] <= deg_wdata;
		end
		deg_rd_q <= deg_mem[deg_addr];
	end

	always_ff @(posedge clk) begin
		if (enq_we) begin
			q_mem[tail_q[VAW-1:0]] <= enq_data;
		end
		q_rd_q <= q_mem[q_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q <= in_word.edge_source;
			dst_q <= in_word.edge_target;
		end
		if (cmd.pop) begin
			cur_v_q <= q_rd_q;
		end
		if (cmd.out_load) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= tsort_pkg::nv_t'(1);
			edge_cnt_q <= '0;
			eidx_q <= '0;
			idx_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				nv_q <= cfg_data;
			end
			if (cmd.edge_clr) begin
				edge_cnt_q <= '0;
			end else if (cmd.add_commit && add_ok) begin
				edge_cnt_q <= edge_cnt_q + ECW'(1);
			end
			if (cmd.eidx_clr) begin
				eidx_q <= '0;
			end else if (cmd.eidx_inc) begin
				eidx_q <= eidx_q + ECW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + tsort_pkg::nv_t'(1);
			end
			if (cmd.q_clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.pop) begin
					head_q <= head_q + tsort_pkg::nv_t'(1);
				end
				if (enq_we) begin
					tail_q <= tail_q + tsort_pkg::nv_t'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.idx_last = ((idx_q + tsort_pkg::nv_t'(1)) == n_eff);
	assign stat.idx_end = (idx_q == n_eff);
	assign stat.edge_end = (eidx_q == edge_cnt_q);
	assign stat.edge_live = ({1'b0, edge_f} < n_eff) && ({1'b0, edge_t} < n_eff);
	assign stat.edge_match = (edge_f == cur_v_q) && ({1'b0, edge_t} < n_eff);
	assign stat.deg_zero = (deg_rd_q == '0);
	assign stat.deg_one = (deg_rd_q == ECW'(1));
	assign stat.q_empty = (head_q == tail_q);
	assign stat.cycle = (head_q < n_eff);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_word = out_q;

endmodule

// File: hw/rtl/tsort_ctrl.sv
// Controller of the topological sort core: sequences edge loads and the
// clear, count, seed, pop/scan and emit phases of a run.
// Depends on tsort_pkg; drives tsort_dp through cmd_t.
module tsort_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input tsort_pkg::stat_t stat,
	output tsort_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ADD = 4'd1;
	localparam logic [3:0] S_CLR = 4'd2;
	localparam logic [3:0] S_CNT_A = 4'd3;
	localparam logic [3:0] S_CNT_B = 4'd4;
	localparam logic [3:0] S_CNT_C = 4'd5;
	localparam logic [3:0] S_SEED_A = 4'd6;
	localparam logic [3:0] S_SEED_B = 4'd7;
	localparam logic [3:0] S_POP_A = 4'd8;
	localparam logic [3:0] S_POP_B = 4'd9;
	localparam logic [3:0] S_SCAN_A = 4'd10;
	localparam logic [3:0] S_SCAN_B = 4'd11;
	localparam logic [3:0] S_SCAN_C = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;
	localparam logic [3:0] S_EMIT_A = 4'd14;
	localparam logic [3:0] S_EMIT_B = 4'd15;

	logic [3:0] state_q, state_next;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.eidx_clr = 1'b1;
					state_next = (opcode == tsort_pkg::OP_RUN) ? S_CLR : S_ADD;
				end
			end
			S_ADD: begin
				if (stat.out_free) begin
					cmd.add_commit = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_kind = tsort_pkg::OUT_ADD;
					state_next = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.deg_sel_idx = 1'b1;
				cmd.deg_op = tsort_pkg::DEG_ZERO;
				cmd.idx_inc = 1'b1;
				if (stat.idx_last) begin
					state_next = S_CNT_A;
				end
			end
			S_CNT_A: begin
				if (stat.edge_end) begin
					cmd.idx_clr = 1'b1;
					cmd.q_clr = 1'b1;
					state_next = S_SEED_A;
				end else begin
					state_next = S_CNT_B;
				end
			end
			S_CNT_B: state_next = S_CNT_C;
			S_CNT_C: begin
				if (stat.edge_live) begin
					cmd.deg_op = tsort_pkg::DEG_INC;
				end
				cmd.eidx_inc = 1'b1;
				state_next = S_CNT_A;
			end
			S_SEED_A: begin
				cmd.deg_sel_idx = 1'b1;
				state_next = stat.idx_end ? S_POP_A : S_SEED_B;
			end
			S_SEED_B: begin
				cmd.deg_sel_idx = 1'b1;
				cmd.enq = stat.deg_zero;
				cmd.enq_sel_idx = 1'b1;
				cmd.idx_inc = 1'b1;
				state_next = S_SEED_A;
			end
			S_POP_A: state_next = stat.q_empty ? S_DONE : S_POP_B;
			S_POP_B: begin
				cmd.pop = 1'b1;
				cmd.eidx_clr = 1'b1;
				state_next = S_SCAN_A;
			end
			S_SCAN_A: state_next = stat.edge_end ? S_POP_A : S_SCAN_B;
			S_SCAN_B: begin
				if (stat.edge_match) begin
					state_next = S_SCAN_C;
				end else begin
					cmd.eidx_inc = 1'b1;
					state_next = S_SCAN_A;
				end
			end
			S_SCAN_C: begin
				if (!stat.deg_zero) begin
					cmd.deg_op = tsort_pkg::DEG_DEC;
					cmd.enq = stat.deg_one;
				end
				cmd.eidx_inc = 1'b1;
				state_next = S_SCAN_A;
			end
			S_DONE: begin
				cmd.edge_clr = 1'b1;
				if (stat.cycle) begin
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = tsort_pkg::OUT_CYCLE;
						state_next = S_IDLE;
					end
				end else begin
					cmd.idx_clr = 1'b1;
					state_next = S_EMIT_A;
				end
			end
			S_EMIT_A: begin
				cmd.q_sel_idx = 1'b1;
				state_next = S_EMIT_B;
			end
			S_EMIT_B: begin
				cmd.q_sel_idx = 1'b1;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = tsort_pkg::OUT_VERTEX;
					cmd.idx_inc = 1'b1;
					state_next = stat.idx_last ? S_IDLE : S_EMIT_A;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// File: tb/tsort_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the topological sort core: tracks num_vertices writes and input words,
// predicts the result words of each one and compares them with the output channel.
// Depends on tsort_pkg.
module tsort_checker
	import tsort_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_word_t in_word,
	input logic out_valid,
	input logic out_ready,
	input out_word_t out_word,
	input logic cfg_we,
	input nv_t cfg_data,
	output int fail_count,
	output int owed
);

	vid_t edge_src [MAX_EDGES];
	vid_t edge_dst [MAX_EDGES];
	int edge_total = 0;
	nv_t vertex_reg = nv_t'(1);
	out_word_t owed_words [$];

	initial fail_count = 0;

	function automatic int live_vertices();
		if (vertex_reg == 0)
			return 1;
		if (vertex_reg > MAX_VERTICES)
			return MAX_VERTICES;
		return int'(vertex_reg);
	endfunction

	function automatic void owe_word(status_t st, vid_t vid, logic fin);
		out_word_t w;
		w.status = st;
		w.vertex_id = vid;
		w.last = fin;
		owed_words.push_back(w);
	endfunction

	// Kahn pass over the stored edges; edges naming a vertex outside the range are skipped
	function automatic void expect_sort();
		int n;
		int head;
		int tail;
		int indeg [MAX_VERTICES];
		vid_t order [MAX_VERTICES];
		vid_t v;
		n = live_vertices();
		head = 0;
		tail = 0;
		for (int i = 0; i < MAX_VERTICES; i++)
			indeg[i] = 0;
		for (int e = 0; e < edge_total; e++)
			if (edge_src[e] < n && edge_dst[e] < n)
				indeg[edge_dst[e]]++;
		for (int i = 0; i < n; i++)
			if (indeg[i] == 0) begin
				order[tail] = vid_t'(i);
				tail++;
			end
		while (head < tail) begin
			v = order[head];
			head++;
			for (int e = 0; e < edge_total; e++)
				if (edge_src[e] == v && edge_dst[e] < n && indeg[edge_dst[e]] != 0) begin
					indeg[edge_dst[e]]--;
					if (indeg[edge_dst[e]] == 0) begin
						order[tail] = edge_dst[e];
						tail++;
					end
				end
		end
		edge_total = 0;
		if (head < n)
			owe_word(ST_CYCLE, '0, 1'b1);
		else
			for (int k = 0; k < n; k++)
				owe_word(ST_OK, order[k], k == n - 1);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			vertex_reg = nv_t'(1);
			edge_total = 0;
			owed_words.delete();
			owed <= 0;
		end else begin
			if (cfg_we)
				vertex_reg = cfg_data;
			if (in_valid && in_ready) begin
				if (in_word.opcode == OP_RUN)
					expect_sort();
				else if (in_word.edge_source >= live_vertices() ||
						in_word.edge_target >= live_vertices())
					owe_word(ST_RANGE, '0, 1'b1);
				else if (edge_total >= MAX_EDGES)
					owe_word(ST_FULL, '0, 1'b1);
				else begin
					edge_src[edge_total] = in_word.edge_source;
					edge_dst[edge_total] = in_word.edge_target;
					edge_total++;
					owe_word(ST_OK, '0, 1'b1);
				end
			end
			if (out_valid && out_ready) begin
				if (owed_words.size() == 0) begin
					$error("unexpected word: status %0d vertex_id %0d last %0d",
						out_word.status, out_word.vertex_id, out_word.last);
					fail_count++;
				end else begin
					want = owed_words.pop_front();
					check_field("status", want.status, out_word.status);
					check_field("vertex_id", want.vertex_id, out_word.vertex_id);
					check_field("last", want.last, out_word.last);
				end
			end
			owed <= owed_words.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the topological sort core testbench: clock, reset, edge/run word stimulus,
// output backpressure and the verdict. Depends on tsort_pkg, tsort_checker and the core.
module tb;
	import tsort_pkg::*;

	localparam int MAX_EDGES = MAX_EDGES_DEF;
	localparam int ITEM_GOAL = 450;

	typedef enum int {SHAPE_DAG, SHAPE_LOOSE, SHAPE_LOOPED, SHAPE_NOISE} shape_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;
	logic cfg_we;
	nv_t cfg_data;
	int fail_count;
	int owed;

	int sent = 0;
	int taken = 0;
	int span = 1;
	int perm [64];

	topological_sort_cycle_detect_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	tsort_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.owed(owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// valid stays high on return; lowered only before a gap or by settle
	task automatic push_word(logic op, int src, int dst);
		int gap;
		gap = (sent % 50 < 12) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{opcode: op, edge_source: vid_t'(src), edge_target: vid_t'(dst)};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic add_edge(int src, int dst);
		push_word(OP_ADD, src, dst);
	endtask

	task automatic run_sort();
		push_word(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_vertices(int v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= nv_t'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		span = (v == 0) ? 1 : ((v > 64) ? 64 : v);
	endtask

	function automatic void shuffle_ids(int n);
		int j;
		int tmp;
		for (int i = 0; i < 64; i++)
			perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
	endfunction

	// receiver: random stalls, one long hold-off while edge words keep coming
	initial begin : sink_side
		int gap;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && taken == 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			gap = (taken % 40 < 10) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		int a;
		int b;
		int edges;
		int pick;
		shape_t shape;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex after reset
		add_edge(0, 0);
		run_sort();
		add_edge(1, 0);
		run_sort();
		set_vertices(0);
		add_edge(0, 1);
		run_sort();
		set_vertices(127);
		add_edge(63, 0);
		add_edge(0, 63);
		run_sort();
		set_vertices(3);
		add_edge(0, 1);
		add_edge(0, 1);
		add_edge(1, 2);
		run_sort();
		// edges beyond the shrunk range drop out of the run
		set_vertices(6);
		add_edge(5, 4);
		add_edge(4, 4);
		add_edge(0, 5);
		add_edge(2, 3);
		set_vertices(4);
		run_sort();
		set_vertices(64);
		run_sort();
		set_vertices(33);
		add_edge(33, 0);
		add_edge(0, 40);
		add_edge(32, 32);
		run_sort();

		// fill the edge store with an acyclic graph, then overflow it
		set_vertices(64);
		shuffle_ids(64);
		for (int k = 0; k < MAX_EDGES; k++) begin
			a = $urandom_range(0, 62);
			b = $urandom_range(a + 1, 63);
			add_edge(perm[a], perm[b]);
		end
		add_edge(0, 63);
		add_edge(63, 0);
		set_vertices(10);
		add_edge(20, 3);
		add_edge(2, 3);
		set_vertices(64);
		run_sort();

		while (sent < ITEM_GOAL) begin
			if ($urandom_range(0, 2) == 0) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					set_vertices(0);
				else if (pick == 1)
					set_vertices($urandom_range(65, 127));
				else if (pick < 4)
					set_vertices($urandom_range(41, 64));
				else if (pick < 7)
					set_vertices($urandom_range(13, 40));
				else
					set_vertices($urandom_range(1, 12));
			end
			pick = $urandom_range(0, 9);
			shape = (pick < 6) ? SHAPE_DAG : (pick < 8) ? SHAPE_LOOSE :
				(pick == 8) ? SHAPE_LOOPED : SHAPE_NOISE;
			shuffle_ids(span);
			edges = $urandom_range(0, 14);
			repeat (edges) begin
				a = $urandom_range(0, (span > 1) ? span - 2 : 0);
				b = (span > 1) ? $urandom_range(a + 1, span - 1) : 0;
				case (shape)
					SHAPE_DAG, SHAPE_LOOPED: begin
						if (span > 1)
							add_edge(perm[a], perm[b]);
					end
					SHAPE_LOOSE: add_edge($urandom_range(0, span - 1),
						$urandom_range(0, span - 1));
					default: add_edge($urandom_range(0, 63), $urandom_range(0, 63));
				endcase
			end
			if (shape == SHAPE_LOOPED) begin
				if (span > 1)
					add_edge(perm[b], perm[a]);
				else
					add_edge(0, 0);
			end
			if (shape != SHAPE_NOISE || $urandom_range(0, 1) == 1)
				run_sort();
		end

		settle();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && owed == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
